/* rtl/abp_pkg.sv */
// Shared constants, types and codes for the acknowledgement bitfield processor.
package abp_pkg;

	localparam int STORE_DEPTH = 256;
	localparam int FIELD_BITS  = 32;

	localparam int IDX_W     = $clog2(STORE_DEPTH);
	localparam int STEP_W    = $clog2(FIELD_BITS + 1);
	localparam int SEQ_W     = 16;
	localparam int BITS_W    = 32;
	localparam int BIT_IDX_W = $clog2(BITS_W);
	localparam int TIME_W    = 64;
	localparam int SIZE_W    = 16;
	localparam int NACK_W    = 8;
	localparam int THR_W     = 8;
	localparam int CNT_W     = 6;
	localparam int BYTES_W   = 22;

	localparam logic [THR_W-1:0]  THR_RESET = 8'd3;
	localparam logic [NACK_W-1:0] NACK_MAX  = 8'hFF;

	localparam logic FUNC_SEND = 1'b0;
	localparam logic FUNC_ACK  = 1'b1;

	typedef struct packed {
		logic              func;
		logic [SEQ_W-1:0]  seq;
		logic [BITS_W-1:0] ack_bits;
		logic [TIME_W-1:0] time_ns;
		logic [SIZE_W-1:0] pkt_size;
	} item_t;

	typedef struct packed {
		logic [CNT_W-1:0]          ack_cnt;
		logic [BYTES_W-1:0]        ack_bytes;
		logic [CNT_W-1:0]          loss_cnt;
		logic                      rtt_valid;
		logic signed [TIME_W-1:0]  rtt_ns;
		logic                      frx_flag;
		logic [SEQ_W-1:0]          frx_seq;
	} result_t;

	typedef struct packed {
		logic [SEQ_W-1:0]  tag;
		logic [TIME_W-1:0] send_time;
		logic [SIZE_W-1:0] bytes;
		logic [NACK_W-1:0] nacks;
	} entry_t;

	typedef struct packed {
		logic              send_wr;
		logic              load_ack;
		logic              rd_en;
		logic [STEP_W-1:0] rd_step;
		logic              ev_en;
		logic [STEP_W-1:0] ev_step;
		logic              out_load;
	} ctl_cmd_t;

endpackage

/* rtl/ack_bitfield_processor_core.sv */
// Top level of the acknowledgement bitfield processor.
// A send beat (func 0) records seq, send time and size in a STORE_DEPTH-entry store indexed by
// seq modulo the depth; the block is ready again on the next cycle. An ack beat (func 1) walks
// the directly acked sequence and then FIELD_BITS bitfield sequences, one store
// read-modify-write per cycle through the single-read, single-write store RAM, and returns one
// result beat; the input is not ready again until that beat is loaded, which waits while the
// previous result is still waiting to be taken. The user must write the retransmit threshold
// through cfg_wr_en/cfg_wr_data while the block is idle (not enforced); it resets to 3.
module ack_bitfield_processor_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  abp_pkg::item_t            in_data,
	output logic                      out_valid,
	input  logic                      out_ready,
	output abp_pkg::result_t          out_data,
	input  logic                      cfg_wr_en,
	input  logic [abp_pkg::THR_W-1:0] cfg_wr_data
);
	import abp_pkg::*;

	ctl_cmd_t cmd;
	logic     out_busy;

	abp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_func  (in_data.func),
		.out_busy (out_busy),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	abp_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.in_data     (in_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.out_ready   (out_ready),
		.out_busy    (out_busy),
		.out_valid   (out_valid),
		.out_data    (out_data)
	);

endmodule

/* rtl/abp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module abp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/abp_ctrl.sv */
// Controller state machine: item intake, store walk sequencing and result hand-off.
module abp_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_func,
	input  logic             out_busy,
	output logic             in_ready,
	output abp_pkg::ctl_cmd_t cmd
);
	import abp_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_LAST,
		S_FIN
	} state_t;

	state_t            state_q;
	logic [STEP_W-1:0] cnt_q;
	logic              ev_q;
	logic [STEP_W-1:0] ev_step_q;
	logic              accept;

	always_comb begin
		in_ready     = (state_q == S_IDLE);
		accept       = in_ready && in_valid;
		cmd.send_wr  = accept && (in_func == FUNC_SEND);
		cmd.load_ack = accept && (in_func == FUNC_ACK);
		cmd.rd_en    = (state_q == S_WALK);
		cmd.rd_step  = cnt_q;
		cmd.ev_en    = ev_q;
		cmd.ev_step  = ev_step_q;
		cmd.out_load = (state_q == S_FIN) && !out_busy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			ev_q      <= 1'b0;
			ev_step_q <= '0;
		end else begin
			ev_q      <= (state_q == S_WALK);
			ev_step_q <= cnt_q;
			unique case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (accept && (in_func == FUNC_ACK)) begin
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					cnt_q <= cnt_q + STEP_W'(1);
					if (cnt_q == STEP_W'(FIELD_BITS)) begin
						state_q <= S_LAST;
					end
				end
				S_LAST: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (!out_busy) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

/* rtl/abp_dp.sv */
// Datapath: sent-packet store, valid bits, walk evaluation, accumulators and result register.
module abp_dp (
	input  logic                      clk,
	input  logic                      arst_n,
	input  abp_pkg::ctl_cmd_t         cmd,
	input  abp_pkg::item_t            in_data,
	input  logic                      cfg_wr_en,
	input  logic [abp_pkg::THR_W-1:0] cfg_wr_data,
	input  logic                      out_ready,
	output logic                      out_busy,
	output logic                      out_valid,
	output abp_pkg::result_t          out_data
);
	import abp_pkg::*;

	logic [THR_W-1:0]       thr_q;
	logic [STORE_DEPTH-1:0] valid_q;
	logic [SEQ_W-1:0]       seq_q;
	logic [BITS_W-1:0]      bits_q;
	logic [TIME_W-1:0]      now_q;
	logic [CNT_W-1:0]       acked_q;
	logic [BYTES_W-1:0]     bytes_q;
	logic [CNT_W-1:0]       lost_q;
	logic                   rtt_valid_q;
	logic [TIME_W-1:0]      rtt_q;
	logic                   frx_q;
	logic [SEQ_W-1:0]       rseq_q;
	logic                   out_valid_q;
	result_t                out_q;

	logic [SEQ_W-1:0]     rd_seq;
	logic [SEQ_W-1:0]     ev_seq;
	logic [IDX_W-1:0]     ev_idx;
	logic [BIT_IDX_W-1:0] bit_idx;
	entry_t               rec;
	logic                 hit;
	logic                 direct;
	logic                 ack_hit;
	logic                 nack_hit;
	logic [NACK_W-1:0]    nacks_new;
	logic                 frx_hit;
	logic                 ram_we;
	logic [IDX_W-1:0]     ram_waddr;
	entry_t               ram_wdata;
	entry_t               send_rec;

	always_comb begin
		rd_seq    = seq_q - SEQ_W'(cmd.rd_step);
		ev_seq    = seq_q - SEQ_W'(cmd.ev_step);
		ev_idx    = ev_seq[IDX_W-1:0];
		bit_idx   = BIT_IDX_W'(cmd.ev_step - STEP_W'(1));
		hit       = valid_q[ev_idx] && (rec.tag == ev_seq);
		direct    = (cmd.ev_step == '0);
		ack_hit   = cmd.ev_en && hit && (direct || bits_q[bit_idx]);
		nack_hit  = cmd.ev_en && hit && !direct && !bits_q[bit_idx];
		nacks_new = (rec.nacks == NACK_MAX) ? NACK_MAX : rec.nacks + NACK_W'(1);
		frx_hit   = nack_hit && (nacks_new >= thr_q);

		send_rec.tag       = in_data.seq;
		send_rec.send_time = in_data.time_ns;
		send_rec.bytes     = in_data.pkt_size;
		send_rec.nacks     = '0;

		ram_we    = cmd.send_wr || nack_hit;
		ram_waddr = cmd.send_wr ? in_data.seq[IDX_W-1:0] : ev_idx;
		ram_wdata = rec;
		ram_wdata.nacks = nacks_new;
		if (cmd.send_wr) begin
			ram_wdata = send_rec;
		end
	end

	abp_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.rd_en),
		.raddr (rd_seq[IDX_W-1:0]),
		.rdata (rec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q       <= THR_RESET;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				thr_q <= cfg_wr_data;
			end
			if (cmd.send_wr) begin
				valid_q[in_data.seq[IDX_W-1:0]] <= 1'b1;
			end else if (ack_hit) begin
				valid_q[ev_idx] <= 1'b0;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_ack) begin
			seq_q       <= in_data.seq;
			bits_q      <= in_data.ack_bits;
			now_q       <= in_data.time_ns;
			acked_q     <= '0;
			bytes_q     <= '0;
			lost_q      <= '0;
			rtt_valid_q <= 1'b0;
			rtt_q       <= '0;
			frx_q       <= 1'b0;
			rseq_q      <= '0;
		end else begin
			if (ack_hit) begin
				acked_q <= acked_q + CNT_W'(1);
				bytes_q <= bytes_q + BYTES_W'(rec.bytes);
			end
			if (ack_hit && direct) begin
				rtt_valid_q <= 1'b1;
				rtt_q       <= now_q - rec.send_time;
			end
			if (nack_hit) begin
				lost_q <= lost_q + CNT_W'(1);
			end
			if (frx_hit) begin
				frx_q  <= 1'b1;
				rseq_q <= ev_seq;
			end
		end
		if (cmd.out_load) begin
			out_q.ack_cnt   <= acked_q;
			out_q.ack_bytes <= bytes_q;
			out_q.loss_cnt  <= lost_q;
			out_q.rtt_valid <= rtt_valid_q;
			out_q.rtt_ns    <= rtt_q;
			out_q.frx_flag  <= frx_q;
			out_q.frx_seq   <= rseq_q;
		end
	end

	assign out_busy  = out_valid_q && !out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

/* rtl/abp_checker.sv */
// Port-level assertions for the acknowledgement bitfield processor, bound to the top level.
module abp_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input abp_pkg::item_t            in_data,
	input logic                      out_valid,
	input logic                      out_ready,
	input abp_pkg::result_t          out_data
);
	import abp_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result beat dropped or changed while stalled");

	a_rtt_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.rtt_valid || (out_data.rtt_ns == '0))
		else $error("rtt_ns non-zero without an RTT sample");

	a_rseq_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.frx_flag || (out_data.frx_seq == '0))
		else $error("frx_seq non-zero without a retransmit flag");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ({1'b0, out_data.ack_cnt} + {1'b0, out_data.loss_cnt})
			<= (CNT_W + 1)'(FIELD_BITS + 1))
		else $error("acked plus lost exceeds the walked sequences");

	a_ack_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_data.func == FUNC_ACK) |=> !in_ready)
		else $error("ack beat did not start a walk");

endmodule

bind ack_bitfield_processor_core abp_checker u_abp_checker (.*);

/* tb/ack_bitfield_processor_core_tb.sv */
// Self-checking testbench for the acknowledgement bitfield processor core.
module ack_bitfield_processor_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import abp_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 48;

	typedef struct {
		item_t beat;
		bit    drain_first;
	} queued_beat_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	item_t             in_data = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	result_t           out_data;
	logic              cfg_wr_en = 1'b0;
	logic [THR_W-1:0]  cfg_wr_data = '0;

	queued_beat_t      tx_backlog[$];
	result_t           pending_reports[$];
	bit                beat_taken = 1'b0;
	int                cycle_count = 0;
	int                error_count = 0;
	logic              calm_window;

	logic              sent_live[STORE_DEPTH];
	logic [SEQ_W-1:0]  sent_tag[STORE_DEPTH];
	logic [TIME_W-1:0] sent_time[STORE_DEPTH];
	logic [SIZE_W-1:0] sent_len[STORE_DEPTH];
	logic [NACK_W-1:0] sent_nacks[STORE_DEPTH];
	logic [THR_W-1:0]  nack_limit = THR_RESET;

	logic [SEQ_W-1:0]  next_seq;
	logic [TIME_W-1:0] clock_ns;

	ack_bitfield_processor_core DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	always #6 clk = ~clk;

	assign calm_window = (cycle_count >= 3000) && (cycle_count < 8000);

	task automatic absorb_beat(input item_t it);
		result_t           r;
		logic [IDX_W-1:0]  ix;
		logic [SEQ_W-1:0]  s;
		int unsigned       acked;
		int unsigned       lost;
		int unsigned       bytes;
		r = '0;
		acked = 0;
		lost = 0;
		bytes = 0;
		ix = IDX_W'(it.seq % STORE_DEPTH);
		if (it.func == FUNC_SEND) begin
			sent_live[ix] = 1'b1;
			sent_tag[ix] = it.seq;
			sent_time[ix] = it.time_ns;
			sent_len[ix] = it.pkt_size;
			sent_nacks[ix] = '0;
		end else begin
			if (sent_live[ix] && sent_tag[ix] == it.seq) begin
				r.rtt_valid = 1'b1;
				r.rtt_ns = it.time_ns - sent_time[ix];
				acked++;
				bytes += sent_len[ix];
				sent_live[ix] = 1'b0;
			end
			for (int i = 0; i < FIELD_BITS; i++) begin
				s = it.seq - SEQ_W'(i + 1);
				ix = IDX_W'(s % STORE_DEPTH);
				if (sent_live[ix] && sent_tag[ix] == s) begin
					if (it.ack_bits[i]) begin
						acked++;
						bytes += sent_len[ix];
						sent_live[ix] = 1'b0;
					end else begin
						if (sent_nacks[ix] != NACK_MAX)
							sent_nacks[ix] = sent_nacks[ix] + 1'b1;
						lost++;
						if (sent_nacks[ix] >= nack_limit) begin
							r.frx_flag = 1'b1;
							r.frx_seq = s;
						end
					end
				end
			end
			r.ack_cnt = CNT_W'(acked);
			r.ack_bytes = BYTES_W'(bytes);
			r.loss_cnt = CNT_W'(lost);
			pending_reports.push_back(r);
		end
	endtask

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h got %0h", $time, name, want, got);
			error_count++;
		end
	endfunction

	task automatic check_report(input result_t got);
		result_t want;
		if (pending_reports.size() == 0) begin
			$display("%0t: unexpected result beat, expected none got %h", $time, got);
			error_count++;
		end else begin
			want = pending_reports.pop_front();
			check_field("ack_cnt", want.ack_cnt, got.ack_cnt);
			check_field("ack_bytes", want.ack_bytes, got.ack_bytes);
			check_field("loss_cnt", want.loss_cnt, got.loss_cnt);
			check_field("rtt_valid", want.rtt_valid, got.rtt_valid);
			check_field("rtt_ns", want.rtt_ns, got.rtt_ns);
			check_field("frx_flag", want.frx_flag, got.frx_flag);
			check_field("frx_seq", want.frx_seq, got.frx_seq);
		end
	endtask

	task automatic queue_beat(input logic func, input logic [SEQ_W-1:0] seq,
			input logic [BITS_W-1:0] bits, input logic [TIME_W-1:0] t,
			input logic [SIZE_W-1:0] size, input bit drain);
		queued_beat_t q;
		q.beat.func = func;
		q.beat.seq = seq;
		q.beat.ack_bits = bits;
		q.beat.time_ns = t;
		q.beat.pkt_size = size;
		q.drain_first = drain;
		tx_backlog.push_back(q);
	endtask

	task automatic add_traffic(input int n);
		int                made;
		int                burst;
		logic [BITS_W-1:0] bits;
		logic [SEQ_W-1:0]  s;
		made = 0;
		while (made < n) begin
			if ($urandom_range(99) < 12) begin
				queue_beat(1'($urandom_range(1)), SEQ_W'($urandom), $urandom,
					{$urandom, $urandom}, SIZE_W'($urandom), 1'b0);
				made++;
			end else begin
				burst = $urandom_range(1, 5);
				repeat (burst) begin
					if ($urandom_range(9) == 0)
						next_seq += SEQ_W'($urandom_range(1, 3));
					s = next_seq;
					if ($urandom_range(19) == 0)
						s = next_seq - SEQ_W'(STORE_DEPTH);
					clock_ns += TIME_W'($urandom_range(1, 5000));
					queue_beat(FUNC_SEND, s, $urandom, clock_ns, SIZE_W'($urandom), 1'b0);
					next_seq++;
					made++;
				end
				case ($urandom_range(4))
					0: bits = $urandom;
					1: bits = $urandom | $urandom;
					2: bits = $urandom & $urandom;
					3: bits = '1;
					default: bits = '0;
				endcase
				clock_ns += TIME_W'($urandom_range(1, 20000));
				queue_beat(FUNC_ACK, next_seq - SEQ_W'(1 + $urandom_range(3)), bits,
					clock_ns, SIZE_W'($urandom), 1'b0);
				made++;
			end
		end
	endtask

	task automatic add_nack_storm();
		logic [SEQ_W-1:0] base;
		base = next_seq;
		for (int i = 0; i < 8; i++) begin
			clock_ns += TIME_W'($urandom_range(1, 100));
			queue_beat(FUNC_SEND, base + SEQ_W'(i), $urandom, clock_ns, SIZE_W'($urandom), 1'b0);
		end
		repeat (257) begin
			clock_ns += TIME_W'($urandom_range(1, 100));
			queue_beat(FUNC_ACK, base + SEQ_W'(8), $urandom & 32'hFFFF_FF00, clock_ns,
				SIZE_W'($urandom), 1'b0);
		end
		next_seq = base + SEQ_W'(9);
	endtask

	task automatic settle();
		while (tx_backlog.size() != 0 || in_valid || pending_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_limit(input logic [THR_W-1:0] v);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		nack_limit = v;
	endtask

	always @(negedge clk) begin
		out_ready <= calm_window || ($urandom_range(99) >= 21);
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || beat_taken) begin
			beat_taken = 1'b0;
			if (tx_backlog.size() != 0
					&& !(tx_backlog[0].drain_first && pending_reports.size() != 0)
					&& (calm_window || $urandom_range(99) >= 21)) begin
				in_data <= tx_backlog[0].beat;
				void'(tx_backlog.pop_front());
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else if (arst_n) begin
			if (in_valid && in_ready) begin
				absorb_beat(in_data);
				beat_taken = 1'b1;
			end
			if (out_valid && out_ready)
				check_report(out_data);
		end
	end

	initial begin
		for (int i = 0; i < STORE_DEPTH; i++) begin
			sent_live[i] = 1'b0;
			sent_nacks[i] = '0;
		end
		next_seq = SEQ_W'($urandom);
		clock_ns = {$urandom, $urandom};
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		queue_beat(FUNC_ACK, 16'h0000, 32'h0, 64'd100, 16'h0, 1'b0);
		queue_beat(FUNC_SEND, 16'hFFFF, 32'hFFFF_FFFF, 64'd1000, 16'hFFFF, 1'b0);
		queue_beat(FUNC_SEND, 16'h0000, 32'h0, 64'd1010, 16'h0000, 1'b0);
		queue_beat(FUNC_SEND, 16'h0001, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF, 16'd1234, 1'b0);
		queue_beat(FUNC_SEND, 16'hFFFE, 32'h0, 64'd990, 16'd100, 1'b0);
		queue_beat(FUNC_ACK, 16'h0002, 32'h0, 64'd500, 16'h0, 1'b0);
		queue_beat(FUNC_ACK, 16'h0002, 32'h0, 64'd600, 16'h0, 1'b0);
		queue_beat(FUNC_ACK, 16'h0001, 32'h0, 64'd0, 16'h0, 1'b0);
		queue_beat(FUNC_SEND, 16'h0100, 32'h0, 64'd2000, 16'd77, 1'b0);
		queue_beat(FUNC_ACK, 16'h0000, 32'h0, 64'd2100, 16'h0, 1'b0);
		queue_beat(FUNC_ACK, 16'h0101, 32'h1, 64'd2200, 16'h0, 1'b0);
		queue_beat(FUNC_ACK, 16'h0000, 32'hFFFF_FFFF, 64'd2300, 16'hFFFF, 1'b0);
		queue_beat(FUNC_SEND, 16'h1234, 32'h0, 64'd3000, 16'd500, 1'b0);
		queue_beat(FUNC_ACK, 16'h1234, 32'hFFFF_FFFF, 64'd3500, 16'h0, 1'b0);
		queue_beat(FUNC_SEND, 16'h2000, 32'h0, 64'd4000, 16'd42, 1'b0);
		queue_beat(FUNC_ACK, 16'h2020, 32'h8000_0000, 64'd4400, 16'h0, 1'b0);
		queue_beat(FUNC_SEND, 16'h3000, 32'h0, 64'd5000, 16'd9, 1'b0);
		queue_beat(FUNC_ACK, 16'h3021, 32'hFFFF_FFFF, 64'd5100, 16'h0, 1'b0);
		queue_beat(FUNC_ACK, 16'h3000, 32'h0, 64'd5200, 16'h0, 1'b0);
		settle();

		set_limit(8'd1);
		add_traffic(90);
		settle();

		set_limit(8'd255);
		add_nack_storm();
		settle();

		set_limit(8'd0);
		add_traffic(80);
		settle();

		set_limit(THR_W'($urandom_range(2, 6)));
		add_traffic(100);
		queue_beat(FUNC_ACK, next_seq - 16'd1, $urandom, clock_ns, SIZE_W'($urandom), 1'b1);
		add_traffic(100);
		settle();

		if (error_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
